/* design/delayed_actuator_command_queue_defines.svh */
// ----------------------------------------------------------------------------
// delayed actuator command queue: assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef DELAYED_ACTUATOR_COMMAND_QUEUE_DEFINES_SVH
`define DELAYED_ACTUATOR_COMMAND_QUEUE_DEFINES_SVH

// same-cycle implication
`define DACQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dacq assertion failed");

// next-cycle implication
`define DACQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dacq assertion failed");

`endif

/* design/dacq_pkg.sv */
// ----------------------------------------------------------------------------
// dacq_pkg
// types and constants of the delayed actuator command queue
// ----------------------------------------------------------------------------
package dacq_pkg;

  localparam int ActW   = 2;
  localparam int PosW   = 8;
  localparam int DelayW = 15;
  localparam int TimeW  = 32;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // one pending command, 57 bits
  typedef struct packed {
    logic [ActW-1:0]   actuator;
    logic [PosW-1:0]   position;
    logic [DelayW-1:0] delay;
    logic [TimeW-1:0]  start;
  } entry_t;

  // scan control toward the result stage
  typedef struct packed {
    logic            push;
    logic            flush;
    logic [ActW-1:0] actuator;
    logic [PosW-1:0] position;
  } release_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

/* design/dacq_mem.sv */
// ----------------------------------------------------------------------------
// dacq_mem
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module dacq_mem #(
  parameter int DEPTH = 12,
  parameter int AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  dacq_pkg::entry_t  wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output dacq_pkg::entry_t  rdata_o
);

  dacq_pkg::entry_t mem [DEPTH];
  dacq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dacq_out.sv */
// ----------------------------------------------------------------------------
// dacq_out
// holds the latest released command one step so the final one gets the last flag
// ----------------------------------------------------------------------------
module dacq_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dacq_pkg::release_t            rel_i,
  output logic                          strobe_o,
  output logic [dacq_pkg::ActW-1:0]     actuator_o,
  output logic [dacq_pkg::PosW-1:0]     position_o,
  output logic                          last_o
);

  logic                      hold_vld_q, hold_vld_d;
  logic [dacq_pkg::ActW-1:0] hold_act_q;
  logic [dacq_pkg::PosW-1:0] hold_pos_q;
  logic                      strobe_q, strobe_d;
  logic [dacq_pkg::ActW-1:0] act_q;
  logic [dacq_pkg::PosW-1:0] pos_q;
  logic                      last_q, last_d;

  always_comb begin
    hold_vld_d = hold_vld_q;
    strobe_d   = 1'b0;
    last_d     = 1'b0;
    if (rel_i.push) begin
      // a newer release exists, so the held one is not last
      strobe_d   = hold_vld_q;
      hold_vld_d = 1'b1;
    end else if (rel_i.flush) begin
      strobe_d   = hold_vld_q;
      last_d     = 1'b1;
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rel_i.push || rel_i.flush) begin
      act_q  <= hold_act_q;
      pos_q  <= hold_pos_q;
      last_q <= last_d;
    end
    if (rel_i.push) begin
      hold_act_q <= rel_i.actuator;
      hold_pos_q <= rel_i.position;
    end
  end

  assign strobe_o   = strobe_q;
  assign actuator_o = act_q;
  assign position_o = pos_q;
  assign last_o     = last_q;

endmodule

/* design/delayed_actuator_command_queue.sv */
// ----------------------------------------------------------------------------
// delayed_actuator_command_queue
// ordered queue of delayed actuator commands, released by time ticks
// ----------------------------------------------------------------------------
// an enqueue transaction (mode 0) leaves busy low; it is dropped without
// notice when the queue already holds QUEUE_DEPTH entries.
// a tick transaction (mode 1) raises busy while it scans the pending entries:
// the scan streams one entry per cycle through the single read port of the
// entry memory, evaluates each entry in the cycle after its read, compacts
// kept entries in place through the write port, and closes with a flush that
// issues the final release.
// every released command shows on the result ports for exactly one cycle with
// result_strobe_o high; the receiver cannot stall, so it must take each one.
// the last release of a tick carries last_release_o and appears in the first
// cycle with busy low; a tick that releases nothing produces no strobe at all.
// ----------------------------------------------------------------------------
`include "delayed_actuator_command_queue_defines.svh"

module delayed_actuator_command_queue #(
  parameter int QUEUE_DEPTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [1:0]  actuator_id_i,
  input  logic [7:0]  position_i,
  input  logic [14:0] delay_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        result_strobe_o,
  output logic [1:0]  actuator_id_out_o,
  output logic [7:0]  position_out_o,
  output logic        last_release_o
);

  // index width of the entry memory, count width reaching the depth itself
  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  dacq_pkg::state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;   // next entry to read
  logic [CntW-1:0] wr_ptr_q, wr_ptr_d;   // next slot for a kept entry
  logic            eval_vld_q, eval_vld_d;
  logic [dacq_pkg::TimeW-1:0] now_q;

  logic accept;
  logic enq_take;
  logic scan_done;
  logic expired;
  logic [dacq_pkg::TimeW-1:0] elapsed;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  dacq_pkg::entry_t  mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  dacq_pkg::entry_t  mem_rdata;

  dacq_pkg::release_t rel;

  assign busy   = (state_q != dacq_pkg::ST_IDLE);
  assign accept = start && !busy;

  // enqueue that finds room
  assign enq_take = accept && (mode_i == dacq_pkg::MODE_ENQUEUE) && (count_q < DepthC);

  // all issued reads consumed and nothing left to evaluate
  assign scan_done = (rd_ptr_q == count_q) && !eval_vld_q;

  // wrapping elapsed time against the stored delay
  assign elapsed = now_q - mem_rdata.start;
  assign expired = elapsed > {{(dacq_pkg::TimeW - dacq_pkg::DelayW){1'b0}}, mem_rdata.delay};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dacq_pkg::ST_IDLE: begin
        if (accept && (mode_i == dacq_pkg::MODE_TICK)) begin
          state_d = dacq_pkg::ST_SCAN;
        end
      end
      dacq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = dacq_pkg::ST_IDLE;
        end
      end
      default: state_d = dacq_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    eval_vld_d   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wr_ptr_q[IdxW-1:0];
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q[IdxW-1:0];
    rel          = '0;
    rel.actuator = mem_rdata.actuator;
    rel.position = mem_rdata.position;
    case (state_q)
      dacq_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode_i == dacq_pkg::MODE_ENQUEUE) begin
            // append at the tail unless full
            if (count_q < DepthC) begin
              mem_we             = 1'b1;
              mem_waddr          = count_q[IdxW-1:0];
              mem_wdata.actuator = actuator_id_i;
              mem_wdata.position = position_i;
              mem_wdata.delay    = delay_ms_i;
              mem_wdata.start    = now_ms_i;
              count_d            = count_q + OneC;
            end
          end else begin
            rd_ptr_d = '0;
            wr_ptr_d = '0;
          end
        end
      end
      dacq_pkg::ST_SCAN: begin
        // read stage: one entry per cycle
        if (rd_ptr_q != count_q) begin
          mem_re     = 1'b1;
          rd_ptr_d   = rd_ptr_q + OneC;
          eval_vld_d = 1'b1;
        end
        // evaluate stage: release, or write back toward the head
        // (write slot never passes the read slot, so no overlap)
        if (eval_vld_q) begin
          if (expired) begin
            rel.push = 1'b1;
          end else begin
            mem_we   = 1'b1;
            wr_ptr_d = wr_ptr_q + OneC;
          end
        end
        if (scan_done) begin
          rel.flush = 1'b1;
          count_d   = wr_ptr_q;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dacq_pkg::ST_IDLE;
      count_q    <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      eval_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      eval_vld_q <= eval_vld_d;
    end
  end

  // tick time stamp, held for the whole scan
  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == dacq_pkg::MODE_TICK)) begin
      now_q <= now_ms_i;
    end
  end

  dacq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dacq_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rel_i      (rel),
    .strobe_o   (result_strobe_o),
    .actuator_o (actuator_id_out_o),
    .position_o (position_out_o),
    .last_o     (last_release_o)
  );

  // occupancy never exceeds the store
  `DACQ_ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= DepthC)
  // compaction never overtakes the read pointer
  `DACQ_ASSERT_IMPLIES(a_wr_behind_rd, clk_i, rst_ni, busy, wr_ptr_q <= rd_ptr_q)
  // results only come out of a scan
  `DACQ_ASSERT_IMPLIES(a_strobe_from_scan, clk_i, rst_ni, result_strobe_o, $past(busy))
  // an enqueue into a non-full queue grows it by one
  `DACQ_ASSERT_NEXT(a_enqueue_grows, clk_i, rst_ni, enq_take, count_q == $past(count_q) + OneC)

endmodule

/* verif/dacq_release_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dacq_release_checker
// tracks accepted enqueue and tick transactions, predicts released commands
// and compares every result strobe against the oldest predicted release
// ----------------------------------------------------------------------------
module dacq_release_checker #(
  parameter int QUEUE_DEPTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        mode_i,
  input  logic [1:0]  actuator_id_i,
  input  logic [7:0]  position_i,
  input  logic [14:0] delay_ms_i,
  input  logic [31:0] now_ms_i,
  input  logic        result_strobe_o,
  input  logic [1:0]  actuator_id_out_o,
  input  logic [7:0]  position_out_o,
  input  logic        last_release_o,
  output int          mismatch_count,
  output int          releases_due
);

  typedef struct packed {
    logic [dacq_pkg::ActW-1:0] actuator;
    logic [dacq_pkg::PosW-1:0] position;
    logic                      last;
  } release_exp_t;

  dacq_pkg::entry_t held_cmds [QUEUE_DEPTH];
  int               held_count;
  release_exp_t     due_releases[$];
  int               error_tally = 0;

  assign mismatch_count = error_tally;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: release mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    error_tally++;
  endtask

  // walk held commands in order: expired ones become releases, the rest compact
  function automatic void predict_tick(input logic [dacq_pkg::TimeW-1:0] now);
    logic [dacq_pkg::TimeW-1:0] elapsed;
    int                         kept;
    int                         expired;
    int                         emitted;
    release_exp_t               rel;
    kept    = 0;
    expired = 0;
    emitted = 0;
    for (int r = 0; r < held_count; r++) begin
      elapsed = now - held_cmds[r].start;
      if (elapsed > {17'd0, held_cmds[r].delay}) expired++;
    end
    for (int r = 0; r < held_count; r++) begin
      elapsed = now - held_cmds[r].start;
      if (elapsed > {17'd0, held_cmds[r].delay}) begin
        rel.actuator = held_cmds[r].actuator;
        rel.position = held_cmds[r].position;
        rel.last     = (emitted == expired - 1);
        due_releases.push_back(rel);
        emitted++;
      end else begin
        held_cmds[kept] = held_cmds[r];
        kept++;
      end
    end
    held_count = kept;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    release_exp_t want;
    if (!rst_ni) begin
      held_count = 0;
      due_releases.delete();
      releases_due <= 0;
    end else begin
      if (result_strobe_o) begin
        if (due_releases.size() == 0) begin
          flag_mismatch("release with nothing pending", int'(actuator_id_out_o), -1);
        end else begin
          want = due_releases.pop_front();
          if (actuator_id_out_o !== want.actuator)
            flag_mismatch("actuator_id_out", int'(actuator_id_out_o), int'(want.actuator));
          if (position_out_o !== want.position)
            flag_mismatch("position_out", int'(position_out_o), int'(want.position));
          if (last_release_o !== want.last)
            flag_mismatch("last_release", int'(last_release_o), int'(want.last));
        end
      end
      if (start && !busy) begin
        if (mode_i == dacq_pkg::MODE_ENQUEUE) begin
          // full queue drops the command silently
          if (held_count < QUEUE_DEPTH) begin
            held_cmds[held_count] = {actuator_id_i, position_i, delay_ms_i, now_ms_i};
            held_count++;
          end
        end else begin
          predict_tick(now_ms_i);
        end
      end
      releases_due <= due_releases.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives enqueue and tick transactions into the delayed command queue and
// lets the release checker compare every released command
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUEUE_DEPTH = 12;
  // cycles with no accepted transaction or release before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // longest scan plus the closing release cycle, with margin
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 6;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        mode_i;
  logic [1:0]  actuator_id_i;
  logic [7:0]  position_i;
  logic [14:0] delay_ms_i;
  logic [31:0] now_ms_i;
  logic        result_strobe_o;
  logic [1:0]  actuator_id_out_o;
  logic [7:0]  position_out_o;
  logic        last_release_o;

  int          mismatch_count;
  int          releases_due;
  int          idle_cycles;
  logic [31:0] clock_ms;

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  delayed_actuator_command_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .actuator_id_i    (actuator_id_i),
    .position_i       (position_i),
    .delay_ms_i       (delay_ms_i),
    .now_ms_i         (now_ms_i),
    .result_strobe_o  (result_strobe_o),
    .actuator_id_out_o(actuator_id_out_o),
    .position_out_o   (position_out_o),
    .last_release_o   (last_release_o)
  );

  dacq_release_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .actuator_id_i    (actuator_id_i),
    .position_i       (position_i),
    .delay_ms_i       (delay_ms_i),
    .now_ms_i         (now_ms_i),
    .result_strobe_o  (result_strobe_o),
    .actuator_id_out_o(actuator_id_out_o),
    .position_out_o   (position_out_o),
    .last_release_o   (last_release_o),
    .mismatch_count   (mismatch_count),
    .releases_due     (releases_due)
  );

  // watchdog: any accepted transaction or release restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[delayed_actuator_command_queue] ERROR");
        $finish;
      end
    end
  end

  // present one transaction and hold it until the block takes it;
  // start stays high so a following call can chain without a gap
  task automatic issue(input logic m, input logic [1:0] act, input logic [7:0] pos,
                       input logic [14:0] dly, input logic [31:0] stamp);
    start         <= 1'b1;
    mode_i        <= m;
    actuator_id_i <= act;
    position_i    <= pos;
    delay_ms_i    <= dly;
    now_ms_i      <= stamp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // random sender gap, one cycle at a time
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // hold off until every predicted release has come out;
  // the checker count is registered, hence the first wait
  task automatic drain(input bit settle);
    start <= 1'b0;
    @(posedge clk_i);
    while (releases_due != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed traffic around a moving time base, some noise
  task automatic random_phase(input int count, input int idle_pct);
    int          kind;
    logic [14:0] dly;
    logic [31:0] stamp;
    clock_ms = $urandom();
    // sometimes start right below the wrap of the millisecond counter
    if ($urandom_range(0, 1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 120);
    for (int i = 0; i < count; i++) begin
      sender_gap(idle_pct);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // noise: any mode, any time stamp
        issue(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)), $urandom());
      end else if (kind < 55) begin
        // enqueue: mostly short delays, now and then a long one
        if ($urandom_range(0, 9) == 0) dly = 15'($urandom_range(0, 32767));
        else dly = 15'($urandom_range(0, 24));
        // stamp slightly behind or, rarely, ahead of the time base
        if ($urandom_range(0, 9) == 0) stamp = clock_ms + $urandom_range(1, 4);
        else stamp = clock_ms - $urandom_range(0, 3);
        issue(dacq_pkg::MODE_ENQUEUE, 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), dly, stamp);
      end else begin
        // tick: time advances a little, payload fields are don't-care
        clock_ms = clock_ms + $urandom_range(0, 10);
        issue(dacq_pkg::MODE_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              15'($urandom_range(0, 32767)), clock_ms);
      end
    end
  endtask

  initial begin
    start         <= 1'b0;
    mode_i        <= dacq_pkg::MODE_ENQUEUE;
    actuator_id_i <= '0;
    position_i    <= '0;
    delay_ms_i    <= '0;
    now_ms_i      <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty queue releases nothing
    issue(dacq_pkg::MODE_TICK, 2'd0, 8'd0, 15'd0, 32'd0);
    // zero delay: elapsed equal to delay holds, one more ms releases
    issue(dacq_pkg::MODE_ENQUEUE, 2'd0, 8'd0, 15'd0, 32'd0);
    issue(dacq_pkg::MODE_TICK, 2'd0, 8'd0, 15'd0, 32'd0);
    issue(dacq_pkg::MODE_TICK, 2'd0, 8'd0, 15'd0, 32'd1);
    // longest delay across the counter wrap, position above 180
    issue(dacq_pkg::MODE_ENQUEUE, 2'd3, 8'd255, 15'd32767, 32'hFFFF_FFFF);
    issue(dacq_pkg::MODE_TICK, 2'd3, 8'd255, 15'd32767, 32'd32766);
    issue(dacq_pkg::MODE_TICK, 2'd3, 8'd255, 15'd32767, 32'd32767);
    // start stamp in the future reads as a huge elapsed time
    issue(dacq_pkg::MODE_ENQUEUE, 2'd2, 8'd90, 15'd5, 32'd1000);
    issue(dacq_pkg::MODE_TICK, 2'd1, 8'd1, 15'd1, 32'd500);
    // fill past capacity: the thirteenth enqueue is dropped
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      issue(dacq_pkg::MODE_ENQUEUE, 2'(i), 8'(180 - i),
            (i % 2 == 1) ? 15'd0 : 15'd100, 32'd2000);
    // first tick pulls the odd entries out of the middle, second the rest
    issue(dacq_pkg::MODE_TICK, 2'd0, 8'd0, 15'd0, 32'd2050);
    issue(dacq_pkg::MODE_TICK, 2'd0, 8'd0, 15'd0, 32'd2101);
    drain(1'b0);

    // sender idles often, then more, then not at all
    random_phase(45, 32);
    drain(1'b0);
    random_phase(45, 75);
    random_phase(45, 0);

    drain(1'b1);
    if (mismatch_count == 0 && releases_due == 0) begin
      $display("[delayed_actuator_command_queue] OK");
    end else begin
      $display("[delayed_actuator_command_queue] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/dacq_pkg.sv
design/dacq_mem.sv
design/dacq_out.sv
design/delayed_actuator_command_queue.sv
verif/dacq_release_checker.sv
verif/testbench.sv
